/* rtl/pdh_pkg.sv */
// ----------------------------------------------------------------------------
// Pair displacement histogram package
// Shared constants, codes, payload structs and helpers for the 2D pair
// displacement histogram.
// ----------------------------------------------------------------------------
package pdh_pkg;

  localparam int X_BINS    = 256;
  localparam int Y_BINS    = 256;
  localparam int COUNT_W   = 32;
  localparam int COL_W     = $clog2(X_BINS);
  localparam int ROW_W     = $clog2(Y_BINS);
  localparam int HIST_DEPTH = X_BINS * Y_BINS;
  localparam int ADDR_W    = $clog2(HIST_DEPTH);
  localparam int CRD_W     = 32;
  localparam int ID_W      = 16;
  localparam int IDX_W     = 8;
  localparam int OUT_CNT_W = 32;
  localparam int BOX_W     = 31;
  localparam int SCALE_W   = 32;
  localparam int DIFF_W    = 34;
  localparam int STEP_W    = $clog2(DIFF_W + 1);
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X        = 4'd0,
    REG_BOX_Y        = 4'd1,
    REG_BOX_Z        = 4'd2,
    REG_PLANE        = 4'd3,
    REG_HALF_RANGE_X = 4'd4,
    REG_HALF_RANGE_Y = 4'd5,
    REG_X_SCALE      = 4'd6,
    REG_Y_SCALE      = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    PLANE_XY = 2'd0,
    PLANE_YZ = 2'd1,
    PLANE_XZ = 2'd2,
    PLANE_ZX = 2'd3
  } plane_e;

  typedef enum logic {
    CMD_ACC  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    K_INC  = 2'd0,
    K_READ = 2'd1,
    K_ZERO = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    F_IDLE  = 3'd0,
    F_DIV   = 3'd1,
    F_RANGE = 3'd2,
    F_MUL   = 3'd3,
    F_PUSH  = 3'd4
  } front_st_e;

  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_WAIT  = 2'd2
  } back_st_e;

  typedef struct packed {
    logic                    cmd;
    logic signed [CRD_W-1:0] ref_x;
    logic signed [CRD_W-1:0] ref_y;
    logic signed [CRD_W-1:0] ref_z;
    logic signed [CRD_W-1:0] other_x;
    logic signed [CRD_W-1:0] other_y;
    logic signed [CRD_W-1:0] other_z;
    logic [ID_W-1:0]         ref_id;
    logic [ID_W-1:0]         other_id;
    logic [IDX_W-1:0]        read_col;
    logic [IDX_W-1:0]        read_row;
  } in_item_t;

  typedef struct packed {
    logic                 counted;
    logic [IDX_W-1:0]     col_index;
    logic [IDX_W-1:0]     row_index;
    logic [OUT_CNT_W-1:0] bin_count;
  } out_item_t;

  typedef struct packed {
    logic [BOX_W-1:0]   box_x;
    logic [BOX_W-1:0]   box_y;
    logic [BOX_W-1:0]   box_z;
    logic [1:0]         plane;
    logic [BOX_W-1:0]   half_range_x;
    logic [BOX_W-1:0]   half_range_y;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } job_t;

  function automatic logic [OUT_CNT_W-1:0] sat_out(input logic [COUNT_W-1:0] c);
    logic [COUNT_W:0] lim;
    lim = (COUNT_W + 1)'({OUT_CNT_W{1'b1}});
    if ({1'b0, c} > lim) begin
      return '1;
    end
    return OUT_CNT_W'(c);
  endfunction

endpackage

/* rtl/pair_displacement_histogram_2d.sv */
// ----------------------------------------------------------------------------
// Pair displacement histogram, two-dimensional
// Bins the minimum image displacement of atom pairs on a chosen plane into
// a saturating 2D histogram and answers bin read requests.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       to block   in_valid_i/in_stall_o  in_data_i (in_item_t)
//  out      from block out_valid_o/out_stall_i out_data_o (out_item_t)
//  cfg      to block   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An accumulate request passes the front end's divide, range, multiply and
// push states, the divide set by the 34-step periodic remainder; a read or
// skipped request goes straight to push. The back end reads a bin when idle
// and writes it back in its wait state, so the front end sets the rate.
// After reset a clearing pass zeroes the 65536 bins; requests are stalled and
// configuration writes are taken during it. A stalled response register
// holds the back end; the queue then fills and stalls the front end.
// ----------------------------------------------------------------------------
module pair_displacement_histogram_2d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pdh_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pdh_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdh_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pdh_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import pdh_pkg::*;

  cfg_t cfg_q;
  logic clear, push, pop, full, empty;
  job_t job_in, job_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_x        <= '0;
      cfg_q.box_y        <= '0;
      cfg_q.box_z        <= '0;
      cfg_q.plane        <= PLANE_XY;
      cfg_q.half_range_x <= BOX_W'(655360);
      cfg_q.half_range_y <= BOX_W'(655360);
      cfg_q.x_scale      <= SCALE_W'(660787);
      cfg_q.y_scale      <= SCALE_W'(660787);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BOX_X:        cfg_q.box_x        <= cfg_data_i[BOX_W-1:0];
        REG_BOX_Y:        cfg_q.box_y        <= cfg_data_i[BOX_W-1:0];
        REG_BOX_Z:        cfg_q.box_z        <= cfg_data_i[BOX_W-1:0];
        REG_PLANE:        cfg_q.plane        <= cfg_data_i[1:0];
        REG_HALF_RANGE_X: cfg_q.half_range_x <= cfg_data_i[BOX_W-1:0];
        REG_HALF_RANGE_Y: cfg_q.half_range_y <= cfg_data_i[BOX_W-1:0];
        REG_X_SCALE:      cfg_q.x_scale      <= cfg_data_i[SCALE_W-1:0];
        REG_Y_SCALE:      cfg_q.y_scale      <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  pdh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clear_i    (clear),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  pdh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty)
  );

  pdh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .clear_o     (clear),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/pdh_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pdh_modu.sv */
// ----------------------------------------------------------------------------
// Periodic remainder unit
// Floored remainder of a signed value by an unsigned box length, one
// quotient bit per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module pdh_modu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pdh_pkg::DIFF_W-1:0]   t_i,
  input  logic        [pdh_pkg::BOX_W-1:0]    b_i,
  output logic                                done_o,
  output logic        [pdh_pkg::BOX_W-1:0]    r_o
);
  import pdh_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DIFF_W-1:0] mag_q, mag_d;
  logic [BOX_W-1:0]  rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [BOX_W:0]    trial;

  always_comb begin
    trial  = {rem_q, mag_q[DIFF_W-1]};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(DIFF_W);
      mag_d  = t_i[DIFF_W-1] ? DIFF_W'(-t_i) : DIFF_W'(t_i);
      rem_d  = '0;
      neg_d  = t_i[DIFF_W-1];
    end else if (busy_q) begin
      mag_d = {mag_q[DIFF_W-2:0], 1'b0};
      if (trial >= {1'b0, b_i}) begin
        rem_d = BOX_W'(trial - {1'b0, b_i});
      end else begin
        rem_d = BOX_W'(trial);
      end
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o = ~busy_q;
  assign r_o    = (neg_q && rem_q != '0) ? BOX_W'(b_i - rem_q) : rem_q;

endmodule

/* rtl/pdh_front.sv */
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts requests, forms the wrapped displacement, range tests and bins
// it, and hands one job per request to the queue.
// ----------------------------------------------------------------------------
module pdh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdh_pkg::cfg_t     cfg_i,
  input  logic              clear_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pdh_pkg::in_item_t in_data_i,
  output logic              push_o,
  output pdh_pkg::job_t     job_o,
  input  logic              full_i
);
  import pdh_pkg::*;

  front_st_e state_q, state_d;

  logic                     accept;
  logic signed [DIFF_W-1:0] dx, dy, dz, dh, dv, th, tv;
  logic        [BOX_W-1:0]  box_h, box_v, r_h, r_v;
  logic                     done_h, done_v;

  logic                     cmd_q, skip_q;
  logic [IDX_W-1:0]         rcol_q, rrow_q;
  logic signed [DIFF_W-1:0] dh_q, dv_q;
  logic signed [DIFF_W-1:0] wh, wv;
  logic                     inh, inv, inh_q, inv_q;
  logic [SCALE_W-1:0]       offh, offv, offh_q, offv_q;
  logic [2*SCALE_W-1:0]     prod_h, prod_v;
  logic [SCALE_W-1:0]       idxh_q, idxv_q;
  logic [COL_W-1:0]         col_sat;
  logic [ROW_W-1:0]         row_sat;

  function automatic logic signed [DIFF_W-1:0] sext(input logic signed [CRD_W-1:0] a);
    return {{(DIFF_W-CRD_W){a[CRD_W-1]}}, a};
  endfunction

  assign dx = sext(in_data_i.other_x) - sext(in_data_i.ref_x);
  assign dy = sext(in_data_i.other_y) - sext(in_data_i.ref_y);
  assign dz = sext(in_data_i.other_z) - sext(in_data_i.ref_z);

  always_comb begin
    case (plane_e'(cfg_i.plane))
      PLANE_XY: begin dh = dx; dv = dy; box_h = cfg_i.box_x; box_v = cfg_i.box_y; end
      PLANE_YZ: begin dh = dy; dv = dz; box_h = cfg_i.box_y; box_v = cfg_i.box_z; end
      PLANE_XZ: begin dh = dx; dv = dz; box_h = cfg_i.box_x; box_v = cfg_i.box_z; end
      PLANE_ZX: begin dh = dz; dv = dx; box_h = cfg_i.box_z; box_v = cfg_i.box_x; end
      default:  begin dh = dx; dv = dy; box_h = cfg_i.box_x; box_v = cfg_i.box_y; end
    endcase
  end

  assign th = dh + DIFF_W'(box_h >> 1);
  assign tv = dv + DIFF_W'(box_v >> 1);

  assign accept = in_valid_i && !in_stall_o;

  pdh_modu u_mod_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .t_i     (th),
    .b_i     (box_h),
    .done_o  (done_h),
    .r_o     (r_h)
  );

  pdh_modu u_mod_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .t_i     (tv),
    .b_i     (box_v),
    .done_o  (done_v),
    .r_o     (r_v)
  );

  always_comb begin
    wh = (box_h == '0) ? dh_q : DIFF_W'(r_h) - DIFF_W'(box_h >> 1);
    wv = (box_v == '0) ? dv_q : DIFF_W'(r_v) - DIFF_W'(box_v >> 1);
    inh = (wh >= -$signed(DIFF_W'(cfg_i.half_range_x))) &&
          (wh <   $signed(DIFF_W'(cfg_i.half_range_x)));
    inv = (wv >= -$signed(DIFF_W'(cfg_i.half_range_y))) &&
          (wv <   $signed(DIFF_W'(cfg_i.half_range_y)));
    offh = SCALE_W'(wh + DIFF_W'(cfg_i.half_range_x));
    offv = SCALE_W'(wv + DIFF_W'(cfg_i.half_range_y));
  end

  assign prod_h = offh_q * cfg_i.x_scale;
  assign prod_v = offv_q * cfg_i.y_scale;

  assign col_sat = (idxh_q >= SCALE_W'(X_BINS - 1)) ? COL_W'(X_BINS - 1) : COL_W'(idxh_q);
  assign row_sat = (idxv_q >= SCALE_W'(Y_BINS - 1)) ? ROW_W'(Y_BINS - 1) : ROW_W'(idxv_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd == CMD_ACC && in_data_i.ref_id != in_data_i.other_id) begin
            state_d = F_DIV;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_DIV:   if (done_h && done_v) state_d = F_RANGE;
      F_RANGE: state_d = F_MUL;
      F_MUL:   state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != F_IDLE) || clear_i;
    push_o     = (state_q == F_PUSH) && !full_i;
    job_o.kind = K_ZERO;
    job_o.col  = '0;
    job_o.row  = '0;
    job_o.addr = '0;
    if (cmd_q == CMD_READ) begin
      job_o.col  = rcol_q;
      job_o.row  = rrow_q;
      job_o.addr = ADDR_W'(ADDR_W'(rcol_q) * ADDR_W'(Y_BINS) + ADDR_W'(rrow_q));
      if (32'(rcol_q) < 32'(X_BINS) && 32'(rrow_q) < 32'(Y_BINS)) begin
        job_o.kind = K_READ;
      end
    end else if (!skip_q && inh_q && inv_q) begin
      job_o.kind = K_INC;
      job_o.col  = IDX_W'(col_sat);
      job_o.row  = IDX_W'(row_sat);
      job_o.addr = ADDR_W'(ADDR_W'(col_sat) * ADDR_W'(Y_BINS) + ADDR_W'(row_sat));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_data_i.cmd;
      skip_q <= (in_data_i.ref_id == in_data_i.other_id);
      rcol_q <= in_data_i.read_col;
      rrow_q <= in_data_i.read_row;
      dh_q   <= dh;
      dv_q   <= dv;
    end
    if (state_q == F_RANGE) begin
      inh_q  <= inh;
      inv_q  <= inv;
      offh_q <= offh;
      offv_q <= offv;
    end
    if (state_q == F_MUL) begin
      idxh_q <= prod_h[2*SCALE_W-1:SCALE_W];
      idxv_q <= prod_v[2*SCALE_W-1:SCALE_W];
    end
  end

endmodule

/* rtl/pdh_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the front end from the histogram back end.
// ----------------------------------------------------------------------------
module pdh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pdh_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output pdh_pkg::job_t job_o,
  output logic          empty_o
);
  import pdh_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

/* rtl/pdh_back.sv */
// ----------------------------------------------------------------------------
// Histogram back end
// Clears the bin memory after reset, then carries out increments and reads,
// answers zero jobs without a memory access and holds the response register.
// ----------------------------------------------------------------------------
module pdh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdh_pkg::job_t      job_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               clear_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pdh_pkg::out_item_t out_data_o
);
  import pdh_pkg::*;

  back_st_e          state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  job_t              job_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              out_free, load;
  logic              we, re;
  logic [ADDR_W-1:0] waddr;
  logic [COUNT_W-1:0] wdata, rdata, newc;

  pdh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (HIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (job_i.addr),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign newc     = (job_q.kind == K_INC && rdata != '1) ? rdata + COUNT_W'(1) : rdata;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: if (clr_q == ADDR_W'(HIST_DEPTH - 1)) state_d = B_IDLE;
      B_IDLE:  if (!empty_i && out_free && job_i.kind != K_ZERO) state_d = B_WAIT;
      B_WAIT:  state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    clear_o = (state_q == B_CLEAR);
    clr_d   = clr_q + ADDR_W'(1);
    pop_o   = (state_q == B_IDLE) && !empty_i && out_free;
    re      = pop_o && job_i.kind != K_ZERO;
    we      = clear_o || (state_q == B_WAIT && job_q.kind == K_INC);
    waddr   = clear_o ? clr_q : job_q.addr;
    wdata   = clear_o ? '0 : newc;
    load    = 1'b0;
    out_d   = out_q;
    if (pop_o && job_i.kind == K_ZERO) begin
      load              = 1'b1;
      out_d.counted     = 1'b0;
      out_d.col_index   = job_i.col;
      out_d.row_index   = job_i.row;
      out_d.bin_count   = '0;
    end else if (state_q == B_WAIT) begin
      load              = 1'b1;
      out_d.counted     = (job_q.kind == K_INC);
      out_d.col_index   = job_q.col;
      out_d.row_index   = job_q.row;
      out_d.bin_count   = sat_out(newc);
    end
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (clear_o) clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (load)  out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/pdh_checker.sv */
// ----------------------------------------------------------------------------
// Pair displacement histogram checker
// Port-level properties of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
module pdh_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input pdh_pkg::in_item_t              in_data_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input pdh_pkg::out_item_t             out_data_o
);
  import pdh_pkg::*;

  a_in_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request withdrawn or changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("response payload changed while stalled");

  a_counted_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.counted |-> out_data_o.bin_count != '0)
    else $error("counted request reports an empty bin");

  a_reset_stall: assert property (@(posedge clk_i)
    !rst_ni |-> in_stall_o)
    else $error("requests accepted while in reset");

endmodule

bind pair_displacement_histogram_2d pdh_checker u_pdh_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Pair displacement histogram testbench
// Drives accumulate and read requests through the histogram in several
// register settings. Each response is checked against a typed value or a
// behavioural copy of the minimum image, binning and saturating counter logic,
// while the sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
  import pdh_pkg::*;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t resp;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  cfg_t        shadow_cfg;
  bit [31:0]   bin_counts [int];
  int          hit_bins [$];
  out_item_t   pending_bins [$];
  dir_row_t    dir_tab [$];
  int          fail_count = 0;
  int          burst_left = 0;
  int          stall_tick = 0;
  int          stall_mode = 0;

  pair_displacement_histogram_2d dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("pair_displacement_histogram_2d verification failed");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 512 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= (stall_tick[3:2] == 2'b11);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bins.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        want = pending_bins.pop_front();
        if (out_data_o.counted !== want.counted) begin
          $error("counted expected %0d actual %0d", want.counted, out_data_o.counted);
          fail_count++;
        end
        if (out_data_o.col_index !== want.col_index) begin
          $error("col_index expected %0d actual %0d", want.col_index, out_data_o.col_index);
          fail_count++;
        end
        if (out_data_o.row_index !== want.row_index) begin
          $error("row_index expected %0d actual %0d", want.row_index, out_data_o.row_index);
          fail_count++;
        end
        if (out_data_o.bin_count !== want.bin_count) begin
          $error("bin_count expected %0d actual %0d", want.bin_count, out_data_o.bin_count);
          fail_count++;
        end
      end
    end
  end

  function automatic longint wrap_disp(longint d, logic [BOX_W-1:0] box);
    longint b, t, q;
    if (box == 0) return d;
    b = longint'(box);
    t = d + (b >>> 1);
    q = t / b;
    if ((t % b) != 0 && t < 0) q--;
    return d - q * b;
  endfunction

  function automatic int bin_of(longint d, logic [BOX_W-1:0] hr, logic [SCALE_W-1:0] sc,
                                int nbins);
    longint     h;
    logic [63:0] off, prod;
    h = longint'(hr);
    if (d < -h || d >= h) return -1;
    off = 64'(d + h);
    prod = off * {32'b0, sc};
    if (prod[63:32] > nbins - 1) return nbins - 1;
    return int'(prod[63:32]);
  endfunction

  function automatic out_item_t predict_bin(in_item_t r);
    out_item_t o;
    longint    dx, dy, dz, hd, vd;
    int        c, w, k;
    o = '0;
    if (r.cmd == CMD_READ) begin
      o.col_index = r.read_col;
      o.row_index = r.read_row;
      k = int'(r.read_col) * Y_BINS + int'(r.read_row);
      if (bin_counts.exists(k)) o.bin_count = bin_counts[k];
      return o;
    end
    if (r.ref_id == r.other_id) return o;
    dx = wrap_disp(longint'(r.other_x) - longint'(r.ref_x), shadow_cfg.box_x);
    dy = wrap_disp(longint'(r.other_y) - longint'(r.ref_y), shadow_cfg.box_y);
    dz = wrap_disp(longint'(r.other_z) - longint'(r.ref_z), shadow_cfg.box_z);
    case (plane_e'(shadow_cfg.plane))
      PLANE_XY: begin hd = dx; vd = dy; end
      PLANE_YZ: begin hd = dy; vd = dz; end
      PLANE_XZ: begin hd = dx; vd = dz; end
      default:  begin hd = dz; vd = dx; end
    endcase
    c = bin_of(hd, shadow_cfg.half_range_x, shadow_cfg.x_scale, X_BINS);
    w = bin_of(vd, shadow_cfg.half_range_y, shadow_cfg.y_scale, Y_BINS);
    if (c < 0 || w < 0) return o;
    k = c * Y_BINS + w;
    if (!bin_counts.exists(k)) begin
      bin_counts[k] = 0;
      hit_bins.insert(hit_bins.size(), k);
    end
    if (bin_counts[k] != 32'hFFFF_FFFF) bin_counts[k]++;
    o.counted = 1'b1;
    o.col_index = c[7:0];
    o.row_index = w[7:0];
    o.bin_count = bin_counts[k];
    return o;
  endfunction

  function automatic in_item_t mk_req(logic cmd, int rx, int ry, int rz, int ox, int oy,
                                      int oz, int rid, int oid, int rc, int rr);
    in_item_t r;
    r.cmd = cmd;
    r.ref_x = rx; r.ref_y = ry; r.ref_z = rz;
    r.other_x = ox; r.other_y = oy; r.other_z = oz;
    r.ref_id = rid[15:0]; r.other_id = oid[15:0];
    r.read_col = rc[7:0]; r.read_row = rr[7:0];
    return r;
  endfunction

  function automatic void add_row(in_item_t r, bit typed, out_item_t o);
    dir_row_t d;
    d.req = r; d.typed = typed; d.resp = o;
    dir_tab.insert(dir_tab.size(), d);
  endfunction

  function automatic int near_coord(int base, longint span, logic [BOX_W-1:0] box);
    longint delta;
    delta = longint'($urandom_range(0, 32'(2 * span))) - span;
    if (box != 0 && $urandom_range(0, 9) < 3)
      delta += longint'(box) * ($urandom_range(0, 1) ? 1 : -1);
    return int'(32'(longint'(base) + delta));
  endfunction

  function automatic in_item_t rand_req();
    in_item_t     r;
    logic [255:0] rnd;
    longint       span;
    int           sel, k;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    r = in_item_t'(rnd[$bits(in_item_t)-1:0]);
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      r.cmd = CMD_READ;
      if (hit_bins.size() > 0 && $urandom_range(0, 1)) begin
        k = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
        r.read_col = IDX_W'(k / Y_BINS);
        r.read_row = IDX_W'(k % Y_BINS);
      end
      return r;
    end
    r.cmd = CMD_ACC;
    if (sel < 28) begin
      r.other_id = r.ref_id;
      return r;
    end
    if (r.other_id == r.ref_id) r.other_id = ~r.ref_id;
    if (sel < 40) return r;
    span = longint'(shadow_cfg.half_range_x > shadow_cfg.half_range_y ?
                    shadow_cfg.half_range_x : shadow_cfg.half_range_y);
    span = span + span / 4 + 64;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    r.other_x = near_coord(r.ref_x, span, shadow_cfg.box_x);
    r.other_y = near_coord(r.ref_y, span, shadow_cfg.box_y);
    r.other_z = near_coord(r.ref_z, span, shadow_cfg.box_z);
    return r;
  endfunction

  task automatic send_req(in_item_t r, bit typed, out_item_t o);
    int gap;
    out_item_t p;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    p = predict_bin(r);
    pending_bins.insert(pending_bins.size(), typed ? o : p);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BOX_X:        shadow_cfg.box_x = data[BOX_W-1:0];
      REG_BOX_Y:        shadow_cfg.box_y = data[BOX_W-1:0];
      REG_BOX_Z:        shadow_cfg.box_z = data[BOX_W-1:0];
      REG_PLANE:        shadow_cfg.plane = data[1:0];
      REG_HALF_RANGE_X: shadow_cfg.half_range_x = data[BOX_W-1:0];
      REG_HALF_RANGE_Y: shadow_cfg.half_range_y = data[BOX_W-1:0];
      REG_X_SCALE:      shadow_cfg.x_scale = data;
      REG_Y_SCALE:      shadow_cfg.y_scale = data;
      default: ;
    endcase
  endtask

  task automatic load_setup(cfg_t c);
    write_reg(REG_BOX_X, {1'($urandom), c.box_x});
    write_reg(REG_BOX_Y, {1'($urandom), c.box_y});
    write_reg(REG_BOX_Z, {1'($urandom), c.box_z});
    write_reg(REG_PLANE, {30'($urandom), c.plane});
    write_reg(REG_HALF_RANGE_X, {1'($urandom), c.half_range_x});
    write_reg(REG_HALF_RANGE_Y, {1'($urandom), c.half_range_y});
    write_reg(REG_X_SCALE, c.x_scale);
    write_reg(REG_Y_SCALE, c.y_scale);
    write_reg(reg_idx_e'($urandom_range(8, 15)), $urandom);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_bins();
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [BOX_W-1:0] pick_len(int sel);
    case (sel)
      0: return '0;
      1: return {BOX_W{1'b1}};
      2: return BOX_W'($urandom_range(1, 64) << 16);
      default: return BOX_W'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] fit_scale(logic [BOX_W-1:0] hr, int nbins);
    longint s;
    if (hr == 0) return SCALE_W'($urandom);
    s = (longint'(nbins) << 31) / longint'(hr);
    if ($urandom_range(0, 3) == 0) s = s * 2;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    return SCALE_W'(s);
  endfunction

  initial begin
    cfg_t      setup;
    out_item_t nil;
    int        ph, n;
    nil = '0;
    shadow_cfg.box_x = '0; shadow_cfg.box_y = '0; shadow_cfg.box_z = '0;
    shadow_cfg.plane = PLANE_XY;
    shadow_cfg.half_range_x = 655360; shadow_cfg.half_range_y = 655360;
    shadow_cfg.x_scale = 660787; shadow_cfg.y_scale = 660787;

    add_row(mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, nil);
    add_row(mk_req(CMD_READ, -1, -1, -1, -1, -1, -1, 'hFFFF, 'hFFFF, 255, 255), 1,
            '{counted: 1'b0, col_index: 8'd255, row_index: 8'd255, bin_count: 32'd0});
    add_row(mk_req(CMD_ACC, 0, 0, 0, 65536, 0, 0, 'h1234, 'h1234, 0, 0), 1, nil);
    add_row(mk_req(CMD_ACC, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                   32'h8000_0000, 0, 'hFFFF, 'hFFFF, 255, 255), 1, nil);
    add_row(mk_req(CMD_ACC, 0, 0, 0, 655360, 0, 0, 1, 2, 0, 0), 1, nil);
    add_row(mk_req(CMD_ACC, 0, 0, 0, -655360, 0, 0, 1, 2, 0, 0), 0, nil);
    add_row(mk_req(CMD_ACC, 0, 0, 0, 0, 655359, 0, 1, 2, 0, 0), 0, nil);
    add_row(mk_req(CMD_ACC, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 3, 4, 0, 0), 1, nil);
    add_row(mk_req(CMD_ACC, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 3, 4, 0, 0), 1, nil);
    add_row(mk_req(CMD_ACC, 0, 0, 0, 0, 0, 0, 0, 'hFFFF, 0, 0), 0, nil);
    add_row(mk_req(CMD_ACC, 12345, -5, 9, 12345, -5, 9, 'hFFFF, 0, 77, 33), 0, nil);
    add_row(mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 100, 100), 0, nil);
    add_row(mk_req(CMD_ACC, 0, 0, 0, 0, -655360, 0, 5, 6, 0, 0), 0, nil);
    add_row(mk_req(CMD_ACC, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 5, 6, 0, 0), 0, nil);
    add_row(mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 201, 100), 0, nil);
    add_row(mk_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 100), 0, nil);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].resp);
    drain_bins();

    for (ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        setup.box_x = {BOX_W{1'b1}}; setup.box_y = {BOX_W{1'b1}};
        setup.box_z = {BOX_W{1'b1}}; setup.plane = PLANE_ZX;
        setup.half_range_x = {BOX_W{1'b1}}; setup.half_range_y = {BOX_W{1'b1}};
        setup.x_scale = '1; setup.y_scale = '1;
      end else if (ph == 1) begin
        setup.box_x = '0; setup.box_y = '0; setup.box_z = '0; setup.plane = PLANE_XY;
        setup.half_range_x = '0; setup.half_range_y = 1;
        setup.x_scale = '0; setup.y_scale = '0;
      end else begin
        setup.box_x = pick_len($urandom_range(0, 3));
        setup.box_y = pick_len($urandom_range(0, 3));
        setup.box_z = pick_len($urandom_range(0, 3));
        setup.plane = (ph < 6) ? 2'(ph - 2) : 2'($urandom);
        setup.half_range_x = pick_len($urandom_range(1, 3));
        setup.half_range_y = pick_len($urandom_range(1, 3));
        setup.x_scale = fit_scale(setup.half_range_x, X_BINS);
        setup.y_scale = fit_scale(setup.half_range_y, Y_BINS);
      end
      load_setup(setup);
      for (n = 0; n < 205; n++) begin
        if (ph == 3 && n == 100) drain_bins();
        send_req(rand_req(), 0, nil);
      end
      drain_bins();
    end

    repeat (100) @(posedge clk_i);
    if (pending_bins.size() != 0) begin
      $error("%0d responses never arrived", pending_bins.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("pair_displacement_histogram_2d verification clean");
    end else begin
      $display("pair_displacement_histogram_2d verification failed");
    end
    $finish;
  end

endmodule
